// ===== hdl/mi3_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_pkg: shared types and widths of the 3x3 matrix inverse
// Word formats, derived datapath widths, pipeline depths and the item types
// of the request, result and internal lane channels.
// ---------------------------------------------------------------------------
package mi3_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int NUM_LANES = 9;

   // Exact integer widths of the adjugate datapath.
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int COF_BITS  = 2 * WORD_BITS + 1;
   localparam int TERM_BITS = 3 * WORD_BITS + 2;
   localparam int DET_BITS  = 3 * WORD_BITS + 3;
   localparam int DEN_BITS  = DET_BITS;

   // Quotient bits produced by the divider, one per stage.
   localparam int Q_BITS   = WORD_BITS + 1;
   localparam int NUM_BITS = COF_BITS + 2 * FRAC_BITS;
   localparam int HI_BITS  = NUM_BITS - Q_BITS;
   localparam int CMP_BITS = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;
   localparam int REM_BITS = DEN_BITS + 1;

   localparam logic [Q_BITS:0] LIM_NEG = (Q_BITS + 1)'(1) << (WORD_BITS - 1);
   localparam logic [Q_BITS:0] LIM_POS = LIM_NEG - (Q_BITS + 1)'(1);

   localparam int FRONT_STAGES = 6;
   localparam int LANE_STAGES  = Q_BITS + 2;
   localparam int PIPE_STAGES  = FRONT_STAGES + LANE_STAGES;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] m00;
      logic signed [WORD_BITS-1:0] m01;
      logic signed [WORD_BITS-1:0] m02;
      logic signed [WORD_BITS-1:0] m10;
      logic signed [WORD_BITS-1:0] m11;
      logic signed [WORD_BITS-1:0] m12;
      logic signed [WORD_BITS-1:0] m20;
      logic signed [WORD_BITS-1:0] m21;
      logic signed [WORD_BITS-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] inv00;
      logic signed [WORD_BITS-1:0] inv01;
      logic signed [WORD_BITS-1:0] inv02;
      logic signed [WORD_BITS-1:0] inv10;
      logic signed [WORD_BITS-1:0] inv11;
      logic signed [WORD_BITS-1:0] inv12;
      logic signed [WORD_BITS-1:0] inv20;
      logic signed [WORD_BITS-1:0] inv21;
      logic signed [WORD_BITS-1:0] inv22;
      logic                        singular;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][COF_BITS-1:0] mag;
      logic [NUM_LANES-1:0]               neg;
      logic [DEN_BITS-1:0]                den;
      logic                               zero;
   } front_res_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 sat;
   } lane_res_type;

endpackage
`default_nettype wire

// ===== hdl/mi3_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_front: cofactors and determinant
// Six pipeline stages: products, cofactors, split determinant products,
// determinant terms, determinant sum, and magnitudes with signs.
// ---------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire req_type       req_data,
   output      front_res_type front
);

   // Operand indices of each cofactor a*b - c*d, row-major entry numbers.
   localparam logic [3:0] COF_A [NUM_LANES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3,
                                               4'd1, 4'd0};
   localparam logic [3:0] COF_B [NUM_LANES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7,
                                               4'd6, 4'd4};
   localparam logic [3:0] COF_C [NUM_LANES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4,
                                               4'd0, 4'd1};
   localparam logic [3:0] COF_D [NUM_LANES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6,
                                               4'd7, 4'd3};
   // Cofactors that pair with the first row in the determinant.
   localparam logic [3:0] DET_IDX [3] = '{4'd0, 4'd3, 4'd6};

   logic signed [WORD_BITS-1:0] m [NUM_LANES];

   logic signed [PROD_BITS-1:0] prod_a_in [NUM_LANES], prod_a_ff [NUM_LANES];
   logic signed [PROD_BITS-1:0] prod_b_in [NUM_LANES], prod_b_ff [NUM_LANES];
   logic signed [WORD_BITS-1:0] row1_ff [3], row2_ff [3];
   logic signed [COF_BITS-1:0]  cof2_in [NUM_LANES], cof2_ff [NUM_LANES];
   logic signed [COF_BITS-1:0]  cof3_ff [NUM_LANES], cof4_ff [NUM_LANES];
   logic signed [COF_BITS-1:0]  cof5_ff [NUM_LANES];
   logic signed [COF_BITS-1:0]  pl_in [3], pl_ff [3];
   logic signed [COF_BITS-1:0]  ph_in [3], ph_ff [3];
   logic signed [TERM_BITS-1:0] term_in [3], term_ff [3];
   logic signed [DET_BITS-1:0]  det_in, det_ff;
   front_res_type               front_in, front_ff;

   assign m[0] = req_data.m00;
   assign m[1] = req_data.m01;
   assign m[2] = req_data.m02;
   assign m[3] = req_data.m10;
   assign m[4] = req_data.m11;
   assign m[5] = req_data.m12;
   assign m[6] = req_data.m20;
   assign m[7] = req_data.m21;
   assign m[8] = req_data.m22;

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         prod_a_in[k] = m[COF_A[k]] * m[COF_B[k]];
         prod_b_in[k] = m[COF_C[k]] * m[COF_D[k]];
         cof2_in[k]   = COF_BITS'(prod_a_ff[k]) - COF_BITS'(prod_b_ff[k]);
      end
      // The cofactor is split into a signed upper and an unsigned lower word.
      for (int k = 0; k < 3; k++) begin
         pl_in[k] = row2_ff[k] * $signed({1'b0, cof2_ff[DET_IDX[k]][WORD_BITS-1:0]});
         ph_in[k] = row2_ff[k] * $signed(cof2_ff[DET_IDX[k]][COF_BITS-1:WORD_BITS]);
         term_in[k] = $signed({ph_ff[k][COF_BITS-1], ph_ff[k], {WORD_BITS{1'b0}}})
                    + TERM_BITS'(pl_ff[k]);
      end
      det_in = DET_BITS'(term_ff[0]) + DET_BITS'(term_ff[1]) + DET_BITS'(term_ff[2]);

      front_in.den  = det_ff[DET_BITS-1] ? (~det_ff + 1'b1) : det_ff;
      front_in.zero = (det_ff == '0);
      for (int k = 0; k < NUM_LANES; k++) begin
         front_in.neg[k] = cof5_ff[k][COF_BITS-1] ^ det_ff[DET_BITS-1];
         front_in.mag[k] = cof5_ff[k][COF_BITS-1] ? (~cof5_ff[k] + 1'b1) : cof5_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         row1_ff   <= '{m[0], m[1], m[2]};
         cof2_ff   <= cof2_in;
         row2_ff   <= row1_ff;
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         cof3_ff   <= cof2_ff;
         term_ff   <= term_in;
         cof4_ff   <= cof3_ff;
         det_ff    <= det_in;
         cof5_ff   <= cof4_ff;
         front_ff  <= front_in;
      end
   end

   assign front = front_ff;

endmodule
`default_nettype wire

// ===== hdl/mi3_lane.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_lane: one inverse entry
// Overflow check, restoring division one quotient bit per stage, then
// rounding and saturation to the word format.
// ---------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*; (
   input  wire logic                                    clock,
   input  wire logic                                    advance,
   input  wire logic [COF_BITS-1:0]                     cof_mag,
   input  wire logic                                    neg,
   input  wire logic [LANE_STAGES-1:0][DEN_BITS-1:0]    den,
   output      lane_res_type                            res
);

   logic [NUM_BITS-1:0] num;
   logic [CMP_BITS-1:0] hi_ext;
   logic                ovf0;

   logic [DEN_BITS-1:0] rem_in [Q_BITS+1], rem_ff [Q_BITS+1];
   logic [Q_BITS-1:0]   lo_in  [Q_BITS+1], lo_ff  [Q_BITS+1];
   logic [Q_BITS-1:0]   q_in   [Q_BITS+1], q_ff   [Q_BITS+1];
   logic                ovf_ff [Q_BITS+1];
   logic                neg_ff [Q_BITS+1];

   logic [Q_BITS:0]     qr, lim, mag;
   logic                rbit;
   lane_res_type        res_in, res_ff;

   // The numerator is the cofactor magnitude scaled by two fraction widths.
   assign num    = NUM_BITS'(cof_mag) << (2 * FRAC_BITS);
   assign hi_ext = CMP_BITS'(num[NUM_BITS-1:Q_BITS]);
   assign ovf0   = hi_ext >= CMP_BITS'(den[0]);

   always_comb begin
      rem_in[0] = ovf0 ? '0 : DEN_BITS'(hi_ext);
      lo_in[0]  = num[Q_BITS-1:0];
      q_in[0]   = '0;
   end

   for (genvar i = 1; i <= Q_BITS; i++) begin : g_step
      logic [REM_BITS-1:0] trial;
      logic                ge;

      assign trial = {rem_ff[i-1], lo_ff[i-1][Q_BITS-1]};
      assign ge    = trial >= {1'b0, den[i]};
      assign rem_in[i] = ge ? DEN_BITS'(trial - {1'b0, den[i]}) : DEN_BITS'(trial);
      assign lo_in[i]  = {lo_ff[i-1][Q_BITS-2:0], 1'b0};
      assign q_in[i]   = {q_ff[i-1][Q_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in[i];
            lo_ff[i]  <= lo_in[i];
            q_ff[i]   <= q_in[i];
            ovf_ff[i] <= ovf_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= rem_in[0];
         lo_ff[0]  <= lo_in[0];
         q_ff[0]   <= q_in[0];
         ovf_ff[0] <= ovf0;
         neg_ff[0] <= neg;
         res_ff    <= res_in;
      end
   end

   // Round to nearest, ties away from zero, on the magnitude.
   always_comb begin
      rbit = {rem_ff[Q_BITS], 1'b0} >= {1'b0, den[Q_BITS+1]};
      qr   = {1'b0, q_ff[Q_BITS]} + (Q_BITS + 1)'(rbit);
      lim  = neg_ff[Q_BITS] ? LIM_NEG : LIM_POS;
      res_in.sat = ovf_ff[Q_BITS] || (qr > lim);
      mag  = res_in.sat ? lim : qr;
      res_in.value = neg_ff[Q_BITS] ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ===== hdl/mi3_merge.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_merge: result assembly and output buffering
// Combines the nine lane results with the singular flag and holds the item
// in an output register backed by one skid register.
// ---------------------------------------------------------------------------
module mi3_merge import mi3_pkg::*; (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire lane_res_type [NUM_LANES-1:0]    lane_res,
   input  wire logic                            zero,
   output      logic                            advance,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      rsp_type                         rsp_data
);

   rsp_type item;
   rsp_type rsp_in, rsp_ff, skid_in, skid_ff;
   logic    rsp_valid_in, rsp_valid_ff, skid_valid_in, skid_valid_ff;
   logic    take, incoming, any_sat;
   logic [NUM_LANES-1:0][WORD_BITS-1:0] val;

   always_comb begin
      any_sat = 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
         val[k]  = zero ? '0 : lane_res[k].value;
         any_sat = any_sat | lane_res[k].sat;
      end
      item.inv00     = val[0];
      item.inv01     = val[1];
      item.inv02     = val[2];
      item.inv10     = val[3];
      item.inv11     = val[4];
      item.inv12     = val[5];
      item.inv20     = val[6];
      item.inv21     = val[7];
      item.inv22     = val[8];
      item.singular  = zero;
      item.saturated = any_sat & ~zero;
   end

   assign advance  = ~skid_valid_ff;
   assign take     = rsp_valid_ff & rsp_ready;
   assign incoming = advance & in_valid;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (incoming) begin
         if (!rsp_valid_ff || take) begin
            rsp_in       = item;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/matrix_inverse_3x3_core.sv =====
// A request item passes six front-end stages, an overflow check, WORD_BITS + 1
// divider stages, a rounding stage and the output register before rsp_valid.
// Throughput: one item per cycle, set by the fully pipelined divider lanes,
// while the skid register is empty.
// Reset: synchronous and active high; it empties the pipeline and the output.
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_inverse_3x3_core: 3x3 fixed-point matrix inverse by the adjugate
// Exact cofactors and determinant, nine divider lanes in parallel and a
// merging output stage with a skid register.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3_core import mi3_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   // The whole pipeline moves as one. It stops only when the skid register
   // is occupied, so an item is still taken while a result waits at the
   // output, and nothing can be lost in the cycle the skid fills.
   logic advance;

   front_res_type                  front;
   lane_res_type [NUM_LANES-1:0]   lane_res;

   logic [PIPE_STAGES-1:0]         vld_in, vld_ff;

   // The determinant magnitude travels beside the lanes, one copy per stage,
   // and is shared by all nine of them.
   logic [DEN_BITS-1:0]            den_ff [1:LANE_STAGES-1];
   logic                           zero_ff [1:LANE_STAGES];
   logic [LANE_STAGES-1:0][DEN_BITS-1:0] den_tap;

   assign req_ready = advance;

   assign vld_in = {vld_ff[PIPE_STAGES-2:0], req_valid & req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[1]  <= front.den;
         zero_ff[1] <= front.zero;
         for (int j = 2; j < LANE_STAGES; j++) begin
            den_ff[j] <= den_ff[j-1];
         end
         for (int j = 2; j <= LANE_STAGES; j++) begin
            zero_ff[j] <= zero_ff[j-1];
         end
      end
   end

   always_comb begin
      den_tap[0] = front.den;
      for (int j = 1; j < LANE_STAGES; j++) begin
         den_tap[j] = den_ff[j];
      end
   end

   mi3_front u_front (
      .clock    (clock),
      .advance  (advance),
      .req_data (req_data),
      .front    (front)
   );

   // One divider lane per inverse entry, in row-major order.
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mi3_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .cof_mag (front.mag[g]),
         .neg     (front.neg[g]),
         .den     (den_tap),
         .res     (lane_res[g])
      );
   end

   // A singular matrix forces all entries to zero and clears the saturation
   // flag; otherwise the flags of the lanes are combined.
   mi3_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PIPE_STAGES-1]),
      .lane_res  (lane_res),
      .zero      (zero_ff[LANE_STAGES]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hdl/mi3_check.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_check: port checks of the matrix inverse
// Observes the top-level ports and flags protocol and result slips.
// ---------------------------------------------------------------------------
module mi3_check import mi3_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A request item that is not taken is held unchanged by the sender.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request item changed while waiting");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // A singular matrix yields an all-zero, unsaturated item.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv00 == '0 && rsp_data.inv01 == '0 && rsp_data.inv02 == '0 &&
         rsp_data.inv10 == '0 && rsp_data.inv11 == '0 && rsp_data.inv12 == '0 &&
         rsp_data.inv20 == '0 && rsp_data.inv21 == '0 && rsp_data.inv22 == '0 &&
         !rsp_data.saturated)
      else $error("singular item has non-zero entries or saturation");

   // The input is refused only while a finished result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input refused with no result pending");

endmodule

bind matrix_inverse_3x3_core mi3_check u_check (.*);
`default_nettype wire
